/* hdl/hsa_pkg.sv */
// ----------------------------------------------------------------------------
// hsa_pkg
// Shared types, constants and arithmetic helpers of the hue/saturation adjuster.
// ----------------------------------------------------------------------------
`default_nettype none

package hsa_pkg;

    localparam int CH_W        = 8;
    localparam int HUE_W       = 8;
    localparam int GAIN_W      = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int DIV_NW      = 16;
    localparam int DIV_DW      = 9;
    localparam int DIV_QW      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int FRONT_STAGES = 3;
    localparam int BACK_STAGES  = DIV_QW + 3;
    localparam int PIPE_CAP    = FRONT_STAGES + QUEUE_DEPTH + BACK_STAGES;

    localparam logic [CFG_IDX_W-1:0] CFG_HUE_SHIFT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_GAIN  = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd256;
    localparam logic [HUE_W-1:0]  HUE_RESET  = 8'd0;

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
        logic [CH_W-1:0] in_alpha;
    } in_pix_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } out_pix_t;

    // channel holding the maximum
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sec_t;

    // sextant of the hue wheel
    typedef enum logic [2:0] {
        SX_0,
        SX_1,
        SX_2,
        SX_3,
        SX_4,
        SX_5
    } sx_t;

    localparam logic [HUE_W-1:0] BASE_GREEN = 8'd85;
    localparam logic [HUE_W-1:0] BASE_BLUE  = 8'd170;

    typedef struct packed {
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [CH_W-1:0]   alpha;
        logic [CH_W-1:0]   vmax;
        logic [DIV_NW-1:0] num_s;
        logic [DIV_NW-1:0] num_h;
        logic [DIV_DW-1:0] den_h;
        logic              neg;
        sec_t              sec;
        logic              flat;
    } qitem_t;

    function automatic logic [CH_W-1:0] sat_chan(
        input logic [CH_W-1:0]   c,
        input logic [CH_W-1:0]   gray,
        input logic [GAIN_W-1:0] gain
    );
        logic signed [9:0]  diff;
        logic signed [19:0] prod;
        logic signed [11:0] sum;
        diff = $signed({2'b00, c}) - $signed({2'b00, gray});
        prod = diff * $signed({1'b0, gain});
        sum  = $signed({4'b0000, gray}) + 12'(prod >>> 8);
        if (sum < 0)
        begin
            return '0;
        end
        else if (sum > 12'sd255)
        begin
            return 8'd255;
        end
        return sum[7:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/hsa_div.sv */
// ----------------------------------------------------------------------------
// hsa_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hsa_div (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic [hsa_pkg::DIV_NW-1:0] num,
    input  wire logic [hsa_pkg::DIV_DW-1:0] den,
    output logic      [hsa_pkg::DIV_QW-1:0] quo
);

    localparam int NW = hsa_pkg::DIV_NW;
    localparam int DW = hsa_pkg::DIV_DW;
    localparam int QW = hsa_pkg::DIV_QW;

    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [NW:0]   trial;
        logic          ge;
        logic [NW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        always_comb
        begin
            trial    = (NW+1)'(den_in) << (QW - 1 - k);
            ge       = {1'b0, rem_in} >= trial;
            rem_next = ge ? NW'({1'b0, rem_in} - trial) : rem_in;
            quo_next = quo_in;
            quo_next[QW-1-k] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

`default_nettype wire

/* hdl/hsa_front.sv */
// ----------------------------------------------------------------------------
// hsa_front
// Saturation step and HSV classification; emits division jobs to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hsa_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire hsa_pkg::in_pix_t            in_data,
    input  wire logic [hsa_pkg::GAIN_W-1:0]  sat_gain,
    output logic                             push_valid,
    input  wire logic                        push_ready,
    output hsa_pkg::qitem_t                  push_item
);

    logic en;

    logic                 va_reg, vb_reg, vc_reg;
    hsa_pkg::in_pix_t     pa_reg, pb_reg;
    logic [7:0]           gray_reg;
    hsa_pkg::qitem_t      qc_reg;

    logic [15:0]          gray_sum;
    logic [7:0]           sr, sg, sb;
    logic [7:0]           mx, mn, d, absn;
    logic signed [8:0]    numv;
    hsa_pkg::qitem_t      qc_next;

    assign en       = !vc_reg || push_ready;
    assign in_ready = en;

    always_comb
    begin
        gray_sum = 16'(in_data.in_red) * 16'd72 + 16'(in_data.in_green) * 16'd152
                 + 16'(in_data.in_blue) * 16'd32;
        sr = hsa_pkg::sat_chan(pa_reg.in_red, gray_reg, sat_gain);
        sg = hsa_pkg::sat_chan(pa_reg.in_green, gray_reg, sat_gain);
        sb = hsa_pkg::sat_chan(pa_reg.in_blue, gray_reg, sat_gain);
    end

    always_comb
    begin
        mx = pb_reg.in_red;
        mn = pb_reg.in_red;
        if (pb_reg.in_green > mx)
        begin
            mx = pb_reg.in_green;
        end
        if (pb_reg.in_blue > mx)
        begin
            mx = pb_reg.in_blue;
        end
        if (pb_reg.in_green < mn)
        begin
            mn = pb_reg.in_green;
        end
        if (pb_reg.in_blue < mn)
        begin
            mn = pb_reg.in_blue;
        end
        d = mx - mn;
        qc_next.red   = pb_reg.in_red;
        qc_next.green = pb_reg.in_green;
        qc_next.blue  = pb_reg.in_blue;
        qc_next.alpha = pb_reg.in_alpha;
        qc_next.vmax  = mx;
        if (pb_reg.in_red == mx)
        begin
            qc_next.sec = hsa_pkg::SEC_RED;
            numv = $signed({1'b0, pb_reg.in_green}) - $signed({1'b0, pb_reg.in_blue});
        end
        else if (pb_reg.in_green == mx)
        begin
            qc_next.sec = hsa_pkg::SEC_GREEN;
            numv = $signed({1'b0, pb_reg.in_blue}) - $signed({1'b0, pb_reg.in_red});
        end
        else
        begin
            qc_next.sec = hsa_pkg::SEC_BLUE;
            numv = $signed({1'b0, pb_reg.in_red}) - $signed({1'b0, pb_reg.in_green});
        end
        qc_next.neg   = numv[8];
        absn          = numv[8] ? 8'(-numv) : numv[7:0];
        qc_next.num_h = 16'(absn) * 16'd85;
        qc_next.num_s = 16'(d) * 16'd255;
        qc_next.den_h = {d, 1'b0};
        qc_next.flat  = (mx <= 8'd1) || (d == 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg          <= in_data;
            gray_reg        <= gray_sum[15:8];
            pb_reg.in_red   <= sr;
            pb_reg.in_green <= sg;
            pb_reg.in_blue  <= sb;
            pb_reg.in_alpha <= pa_reg.in_alpha;
            qc_reg          <= qc_next;
        end
    end

    assign push_valid = vc_reg;
    assign push_item  = qc_reg;

endmodule

`default_nettype wire

/* hdl/hsa_queue.sv */
// ----------------------------------------------------------------------------
// hsa_queue
// Short item queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module hsa_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire hsa_pkg::qitem_t push_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output hsa_pkg::qitem_t      pop_item
);

    localparam int DEPTH = hsa_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    hsa_pkg::qitem_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign push_ready = cnt_reg != CW'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? PW'(wr_reg + 1'b1) : wr_reg;
        rd_next  = do_pop ? PW'(rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = CW'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = CW'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* hdl/hsa_back.sv */
// ----------------------------------------------------------------------------
// hsa_back
// Saturation and hue divisions, hue offset and six-sector HSV to RGB.
// ----------------------------------------------------------------------------
`default_nettype none

module hsa_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       pop_valid,
    output logic                            pop_ready,
    input  wire hsa_pkg::qitem_t            pop_item,
    input  wire logic [hsa_pkg::HUE_W-1:0]  hue_shift,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output hsa_pkg::out_pix_t               out_data
);

    localparam int QW = hsa_pkg::DIV_QW;

    logic en;

    logic            dv_reg [QW];
    hsa_pkg::qitem_t sb_reg [QW];
    logic [7:0]      quo_s, quo_h;

    logic            vx_reg, vy_reg, vo_reg;
    logic [7:0]      hx_reg, sx_reg;
    hsa_pkg::qitem_t ix_reg, iy_reg;
    logic [7:0]      h_next, hq, base;

    logic [10:0]     h6;
    logic [7:0]      f;
    logic [15:0]     sf;
    logic [16:0]     sft;
    logic [2:0]      sxt_reg;
    logic [7:0]      kq_reg, kt_reg;
    logic [8:0]      ps_reg;
    logic            small_reg;

    logic [16:0]     pm, qm, tm;
    logic [7:0]      p, q, t;
    hsa_pkg::out_pix_t od_reg, od_next;

    assign en        = !vo_reg || out_ready;
    assign pop_ready = en;

    hsa_div u_div_s (
        .clk (clk),
        .en  (en),
        .num (pop_item.num_s),
        .den ({1'b0, pop_item.vmax}),
        .quo (quo_s)
    );

    hsa_div u_div_h (
        .clk (clk),
        .en  (en),
        .num (pop_item.num_h),
        .den (pop_item.den_h),
        .quo (quo_h)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QW; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
            vx_reg <= 1'b0;
            vy_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= pop_valid;
            for (int i = 1; i < QW; i++)
            begin
                dv_reg[i] <= dv_reg[i-1];
            end
            vx_reg <= dv_reg[QW-1];
            vy_reg <= vx_reg;
            vo_reg <= vy_reg;
        end
    end

    always_comb
    begin
        case (sb_reg[QW-1].sec)
            hsa_pkg::SEC_GREEN: base = hsa_pkg::BASE_GREEN;
            hsa_pkg::SEC_BLUE:  base = hsa_pkg::BASE_BLUE;
            default:            base = '0;
        endcase
        hq     = sb_reg[QW-1].neg ? 8'(8'd0 - quo_h) : quo_h;
        h_next = 8'(base + hq + hue_shift);
    end

    always_comb
    begin
        h6  = 11'(hx_reg) * 11'd6;
        f   = h6[7:0];
        sf  = 16'(sx_reg) * 16'(f);
        sft = 17'(sx_reg) * (17'd256 - 17'(f));
    end

    always_comb
    begin
        pm = 17'(iy_reg.vmax) * 17'(ps_reg);
        qm = 17'(iy_reg.vmax) * (17'd256 - 17'(kq_reg));
        tm = 17'(iy_reg.vmax) * (17'd256 - 17'(kt_reg));
        p  = pm[15:8];
        q  = qm[15:8];
        t  = tm[15:8];
        od_next.out_alpha = iy_reg.alpha;
        if (hue_shift == '0)
        begin
            od_next.out_red   = iy_reg.red;
            od_next.out_green = iy_reg.green;
            od_next.out_blue  = iy_reg.blue;
        end
        else if (small_reg)
        begin
            od_next.out_red   = iy_reg.vmax;
            od_next.out_green = iy_reg.vmax;
            od_next.out_blue  = iy_reg.vmax;
        end
        else
        begin
            case (hsa_pkg::sx_t'(sxt_reg))
                hsa_pkg::SX_0:
                begin
                    od_next.out_red   = iy_reg.vmax;
                    od_next.out_green = t;
                    od_next.out_blue  = p;
                end
                hsa_pkg::SX_1:
                begin
                    od_next.out_red   = q;
                    od_next.out_green = iy_reg.vmax;
                    od_next.out_blue  = p;
                end
                hsa_pkg::SX_2:
                begin
                    od_next.out_red   = p;
                    od_next.out_green = iy_reg.vmax;
                    od_next.out_blue  = t;
                end
                hsa_pkg::SX_3:
                begin
                    od_next.out_red   = p;
                    od_next.out_green = q;
                    od_next.out_blue  = iy_reg.vmax;
                end
                hsa_pkg::SX_4:
                begin
                    od_next.out_red   = t;
                    od_next.out_green = p;
                    od_next.out_blue  = iy_reg.vmax;
                end
                default:
                begin
                    od_next.out_red   = iy_reg.vmax;
                    od_next.out_green = p;
                    od_next.out_blue  = q;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= pop_item;
            for (int i = 1; i < QW; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
            ix_reg    <= sb_reg[QW-1];
            hx_reg    <= h_next;
            sx_reg    <= sb_reg[QW-1].flat ? 8'd0 : quo_s;
            iy_reg    <= ix_reg;
            sxt_reg   <= h6[10:8];
            kq_reg    <= sf[15:8];
            kt_reg    <= sft[15:8];
            ps_reg    <= 9'd256 - 9'(sx_reg);
            small_reg <= sx_reg <= 8'd1;
            od_reg    <= od_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_data  = od_reg;

endmodule

`default_nettype wire

/* hdl/hsv_hue_saturation_adjust.sv */
// ----------------------------------------------------------------------------
// hsv_hue_saturation_adjust
// RGBA8 hue rotation and saturation gain, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// in_valid/in_ready carry one RGBA8 pixel per item, out_valid/out_ready one
// adjusted pixel per item, in order. cfg_write with cfg_index selects
// hue_shift (index 0) or saturation_gain (index 1); write only while idle.
// Throughput is one item per cycle unless the output stalls: every unit is
// fully pipelined, the two divisions in eight-stage restoring dividers of one
// quotient bit each. Input to output: three front stages (the first loaded
// at the accept edge), the queue, eight divider stages, hue offset, sextant
// weights and the output register.
// When out_ready is low the back part holds, the four-entry queue fills,
// then the front part holds and in_ready drops; no item is lost.
// Reset clears all valid state and sets hue_shift 0, saturation_gain 256.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_hue_saturation_adjust (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire hsa_pkg::in_pix_t                in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output hsa_pkg::out_pix_t                    out_data,
    input  wire logic                            cfg_write,
    input  wire logic [hsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [hsa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [hsa_pkg::HUE_W-1:0]  hue_reg;
    logic [hsa_pkg::GAIN_W-1:0] gain_reg;

    logic            push_valid, push_ready, pop_valid, pop_ready;
    hsa_pkg::qitem_t push_item, pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_reg  <= hsa_pkg::HUE_RESET;
            gain_reg <= hsa_pkg::GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hsa_pkg::CFG_HUE_SHIFT: hue_reg  <= cfg_data[hsa_pkg::HUE_W-1:0];
                hsa_pkg::CFG_SAT_GAIN:  gain_reg <= cfg_data[hsa_pkg::GAIN_W-1:0];
                default:                ;
            endcase
        end
    end

    hsa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .sat_gain   (gain_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    hsa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    hsa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .hue_shift (hue_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

/* hdl/hsa_checker.sv */
// ----------------------------------------------------------------------------
// hsa_checker
// Port-level checks of the adjuster: output hold and item accounting.
// ----------------------------------------------------------------------------
`default_nettype none

module hsa_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_ready,
    input  wire logic                            out_valid,
    input  wire logic                            out_ready,
    input  wire hsa_pkg::out_pix_t               out_data
);

    localparam int CW = $clog2(hsa_pkg::PIPE_CAP + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_acc && !out_acc)
        begin
            cnt_next = CW'(cnt_reg + 1'b1);
        end
        else if (out_acc && !in_acc)
        begin
            cnt_next = CW'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("output item changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> cnt_reg != '0)
        else $error("output item without a pending input item");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(hsa_pkg::PIPE_CAP))
        else $error("more items in flight than the pipeline holds");

endmodule

bind hsv_hue_saturation_adjust hsa_checker u_chk (.*);

`default_nettype wire
